>>> design/bpfm_pkg.sv
// Package: request and status codes, the engine state type and field widths.
package bpfm_pkg;

  typedef enum logic [1:0] {
    REQ_FETCH     = 2'd0,
    REQ_UNPIN     = 2'd1,
    REQ_FLUSH     = 2'd2,
    REQ_FLUSH_ALL = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_HIT        = 4'd0,
    ST_LOAD_FREE  = 4'd1,
    ST_LOAD_EVICT = 4'd2,
    ST_NO_FRAME   = 4'd3,
    ST_UNPINNED   = 4'd4,
    ST_NOT_RES    = 4'd5,
    ST_FLUSH_WR   = 4'd6,
    ST_FLUSH_NONE = 4'd7,
    ST_FLUSH_DONE = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_EXEC  = 2'd1,
    BK_SCAN  = 2'd2
  } back_state_e;

  localparam int unsigned FIELD_PAGE_BITS = 24;
  localparam int unsigned FIELD_FRAME_BITS = 4;

endpackage

>>> design/bpfm_cmd_fifo.sv
// Two-entry command queue between the request front end and the pool engine.
module bpfm_cmd_fifo #(
  parameter int unsigned WIDTH = 27
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
`endif
endmodule

>>> design/bpfm_engine.sv
// Pool engine: frame table, LRU list, and result generation for one command.
module bpfm_engine #(
  parameter int unsigned NUM_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 24,
  parameter int unsigned PIN_BITS   = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_valid_i,
  input  logic [1:0]                           cmd_type_i,
  input  logic [PAGE_BITS-1:0]                 cmd_page_i,
  input  logic                                 cmd_dirty_i,
  output logic                                 cmd_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [3:0]                           status_o,
  output logic [3:0]                           frame_index_o,
  output logic                                 disk_read_o,
  output logic                                 disk_write_o,
  output logic [bpfm_pkg::FIELD_PAGE_BITS-1:0] write_page_o,
  output logic                                 last_o
);
  import bpfm_pkg::*;

  localparam int unsigned IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned LW = $clog2(NUM_FRAMES + 1);
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  logic [NUM_FRAMES-1:0] valid_q, valid_d, dirty_q, dirty_d;
  logic [PAGE_BITS-1:0] page_q [NUM_FRAMES];
  logic [PAGE_BITS-1:0] page_d [NUM_FRAMES];
  logic [PIN_BITS-1:0]  pins_q [NUM_FRAMES];
  logic [PIN_BITS-1:0]  pins_d [NUM_FRAMES];
  logic [IW-1:0]        lru_q [NUM_FRAMES];
  logic [IW-1:0]        lru_d [NUM_FRAMES];
  logic [LW-1:0]        len_q, len_d;

  back_state_e state_q, state_d;

  logic          ov_q, ov_d;
  logic [3:0]    ost_q, ost_d;
  logic [3:0]    ofr_q, ofr_d;
  logic          ord_q, ord_d, owr_q, owr_d, olast_q, olast_d;
  logic [FIELD_PAGE_BITS-1:0] owp_q, owp_d;

  logic [NUM_FRAMES-1:0] hit_vec, lru_match;
  logic          hit;
  logic [IW-1:0] hit_idx, free_idx, lru_pos;
  logic          free_any, lru_found;
  logic          out_free;

  logic [NUM_FRAMES-1:0] dv, dv_rest;
  logic [IW-1:0]         dv_idx;
  logic                  dv_more;

  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      hit_vec[i] = valid_q[i] && (page_q[i] == cmd_page_i);
      if (hit_vec[i]) begin
        hit = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    lru_found = 1'b0;
    lru_pos = '0;
    for (int j = NUM_FRAMES - 1; j >= 0; j--) begin
      lru_match[j] = (LW'(j) < len_q) && (lru_q[j] == hit_idx);
      if (lru_match[j]) begin
        lru_found = 1'b1;
        lru_pos = IW'(j);
      end
    end
  end

  always_comb begin
    dv = valid_q & dirty_q;
    dv_idx = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (dv[i]) begin
        dv_idx = IW'(i);
      end
    end
    dv_rest = dv;
    dv_rest[dv_idx] = 1'b0;
    dv_more = |dv_rest;
  end

  function automatic logic [3:0] fr4(logic [IW-1:0] x);
    return 4'(x);
  endfunction

  function automatic logic [FIELD_PAGE_BITS-1:0] pg(logic [PAGE_BITS-1:0] x);
    return FIELD_PAGE_BITS'(x);
  endfunction

  always_comb begin
    logic [IW-1:0] v;
    logic [PIN_BITS-1:0] np;
    logic rm;
    logic [IW-1:0] rm_pos;
    logic push;
    valid_d = valid_q;
    dirty_d = dirty_q;
    page_d  = page_q;
    pins_d  = pins_q;
    lru_d   = lru_q;
    len_d   = len_q;
    state_d = state_q;
    cmd_pop_o = 1'b0;
    v = lru_q[0];
    np = '0;
    rm = 1'b0;
    rm_pos = '0;
    push = 1'b0;
    ov_d = ov_q && !out_ready_i;
    ost_d = ost_q;
    ofr_d = ofr_q;
    ord_d = ord_q;
    owr_d = owr_q;
    owp_d = owp_q;
    olast_d = olast_q;

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (out_free) begin
          ov_d = 1'b1;
          ost_d = ST_NOT_RES;
          ofr_d = '0;
          ord_d = 1'b0;
          owr_d = 1'b0;
          owp_d = '0;
          olast_d = 1'b1;
          cmd_pop_o = 1'b1;
          state_d = BK_IDLE;
          case (req_e'(cmd_type_i))
            REQ_FETCH: begin
              if (hit) begin
                if (pins_q[hit_idx] != PIN_MAX) begin
                  pins_d[hit_idx] = pins_q[hit_idx] + 1'b1;
                end
                rm = lru_found;
                rm_pos = lru_pos;
                ost_d = ST_HIT;
                ofr_d = fr4(hit_idx);
              end else if (free_any) begin
                valid_d[free_idx] = 1'b1;
                page_d[free_idx] = cmd_page_i;
                pins_d[free_idx] = PIN_BITS'(1);
                dirty_d[free_idx] = 1'b0;
                ost_d = ST_LOAD_FREE;
                ofr_d = fr4(free_idx);
                ord_d = 1'b1;
              end else if (len_q == '0) begin
                ost_d = ST_NO_FRAME;
              end else begin
                rm = 1'b1;
                rm_pos = '0;
                page_d[v] = cmd_page_i;
                pins_d[v] = PIN_BITS'(1);
                dirty_d[v] = 1'b0;
                ost_d = ST_LOAD_EVICT;
                ofr_d = fr4(v);
                ord_d = 1'b1;
                owr_d = dirty_q[v];
                owp_d = dirty_q[v] ? pg(page_q[v]) : '0;
              end
            end
            REQ_UNPIN: begin
              if (hit) begin
                np = (pins_q[hit_idx] != '0) ? pins_q[hit_idx] - 1'b1 : '0;
                pins_d[hit_idx] = np;
                if (cmd_dirty_i) begin
                  dirty_d[hit_idx] = 1'b1;
                end
                if (np == '0) begin
                  rm = lru_found;
                  rm_pos = lru_pos;
                  push = 1'b1;
                end
                ost_d = ST_UNPINNED;
                ofr_d = fr4(hit_idx);
              end
            end
            REQ_FLUSH: begin
              if (hit) begin
                ofr_d = fr4(hit_idx);
                if (dirty_q[hit_idx]) begin
                  dirty_d[hit_idx] = 1'b0;
                  ost_d = ST_FLUSH_WR;
                  owr_d = 1'b1;
                  owp_d = pg(page_q[hit_idx]);
                end else begin
                  ost_d = ST_FLUSH_NONE;
                end
              end
            end
            default: begin
              ov_d = ov_q && !out_ready_i;
              cmd_pop_o = 1'b0;
              state_d = BK_SCAN;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (out_free) begin
          ov_d = 1'b1;
          ord_d = 1'b0;
          if (dv == '0) begin
            ost_d = ST_FLUSH_DONE;
            ofr_d = '0;
            owr_d = 1'b0;
            owp_d = '0;
            olast_d = 1'b1;
            cmd_pop_o = 1'b1;
            state_d = BK_IDLE;
          end else begin
            dirty_d[dv_idx] = 1'b0;
            ost_d = ST_FLUSH_WR;
            ofr_d = fr4(dv_idx);
            owr_d = 1'b1;
            owp_d = pg(page_q[dv_idx]);
            olast_d = !dv_more;
            if (!dv_more) begin
              cmd_pop_o = 1'b1;
              state_d = BK_IDLE;
            end
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase

    if (rm) begin
      for (int j = 0; j < NUM_FRAMES - 1; j++) begin
        if (IW'(j) >= rm_pos) begin
          lru_d[j] = lru_q[j + 1];
        end
      end
      len_d = len_q - 1'b1;
    end
    if (push) begin
      lru_d[IW'(len_d)] = hit_idx;
      len_d = len_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      len_q   <= '0;
      state_q <= BK_IDLE;
      ov_q    <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        pins_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      len_q   <= len_d;
      state_q <= state_d;
      ov_q    <= ov_d;
      pins_q  <= pins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    lru_q  <= lru_d;
    ost_q  <= ost_d;
    ofr_q  <= ofr_d;
    ord_q  <= ord_d;
    owr_q  <= owr_d;
    owp_q  <= owp_d;
    olast_q <= olast_d;
  end

  assign out_valid_o   = ov_q;
  assign status_o      = ost_q;
  assign frame_index_o = ofr_q;
  assign disk_read_o   = ord_q;
  assign disk_write_o  = owr_q;
  assign write_page_o  = owp_q;
  assign last_o        = olast_q;

`ifndef NO_ASSERTIONS
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(NUM_FRAMES)) else $error("lru length out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result changed while stalled");
  a_read_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (disk_read_o == (status_o == ST_LOAD_FREE ||
                                     status_o == ST_LOAD_EVICT)))
    else $error("disk read mismatch");
`endif
endmodule

>>> design/buffer_pool_frame_manager.sv
// Top level of the buffer pool frame manager.
// Requests enter on req_valid_i/req_ready_o: type, page number and dirty flag.
// Results leave on rsp_valid_o/rsp_ready_i, one transfer per result; last_o
// marks the final result of a request. Fetch, unpin and flush give one result,
// flush-all gives one per dirty frame or a single flush-all-done result.
// A request is queued in a two-entry command queue, so requests are taken
// while the engine works. The engine picks up a command in its idle state
// and executes it in its exec state, which registers the result; it takes
// one command at a time. Flush-all moves on from the exec state to a scan
// state, which gives one result per cycle in ascending frame order while
// the receiver takes them.
// Reset frees all frames, clears pin counts, dirty marks and the LRU list.
// A stalled receiver holds the registered result; the engine stops and the
// queue fills, then req_ready_o drops.
module buffer_pool_frame_manager #(
  parameter int unsigned NUM_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 24,
  parameter int unsigned PIN_BITS   = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 req_valid_i,
  output logic                                 req_ready_o,
  input  logic [1:0]                           req_type_i,
  input  logic [bpfm_pkg::FIELD_PAGE_BITS-1:0] page_number_i,
  input  logic                                 dirty_in_i,
  output logic                                 rsp_valid_o,
  input  logic                                 rsp_ready_i,
  output logic [3:0]                           status_o,
  output logic [3:0]                           frame_index_o,
  output logic                                 disk_read_o,
  output logic                                 disk_write_o,
  output logic [bpfm_pkg::FIELD_PAGE_BITS-1:0] write_page_o,
  output logic                                 last_o
);
  import bpfm_pkg::*;

  localparam int unsigned CW = 3 + PAGE_BITS;

  logic          full, empty, pop;
  logic [CW-1:0] cmd;

  assign req_ready_o = !full;

  bpfm_cmd_fifo #(.WIDTH(CW)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (req_valid_i && !full),
    .push_data_i ({req_type_i, PAGE_BITS'(page_number_i), dirty_in_i}),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (cmd),
    .empty_o     (empty)
  );

  bpfm_engine #(
    .NUM_FRAMES(NUM_FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .PIN_BITS  (PIN_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!empty),
    .cmd_type_i   (cmd[CW-1 -: 2]),
    .cmd_page_i   (cmd[PAGE_BITS:1]),
    .cmd_dirty_i  (cmd[0]),
    .cmd_pop_o    (pop),
    .out_valid_o  (rsp_valid_o),
    .out_ready_i  (rsp_ready_i),
    .status_o     (status_o),
    .frame_index_o(frame_index_o),
    .disk_read_o  (disk_read_o),
    .disk_write_o (disk_write_o),
    .write_page_o (write_page_o),
    .last_o       (last_o)
  );
endmodule
